// ===== src/vcts_pkg.sv =====
// Package for the visited-cell trail stack.
// Holds the sequencer state type, register map and the result record.
// No dependencies.
package vcts_pkg;

  // Width of the reported trail length
  localparam int unsigned LEN_W = 9;

  // Width of the fixed coordinate and goal fields on the ports
  localparam int unsigned FIELD_W = 8;

  // Register map: index is address bit 2
  localparam logic REG_GOAL_X = 1'b0;
  localparam logic REG_GOAL_Y = 1'b1;

  // Goal register reset values
  localparam logic [FIELD_W-1:0] GOAL_X_RESET = 8'd2;
  localparam logic [FIELD_W-1:0] GOAL_Y_RESET = 8'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic             overflow;
    logic             at_goal;
  } result_t;

endpackage

// ===== src/vcts_trail_mem.sv =====
// Trail storage: one write port and one read port with registered read data.
// Uses no package items.
module vcts_trail_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/vcts_cfg.sv =====
// APB-style register block holding the goal cell coordinates.
// Depends on vcts_pkg for the register map and reset values.
module vcts_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [7:0]  goal_x,
  output logic [7:0]  goal_y
);

  logic [7:0] goal_x_r;
  logic [7:0] goal_x_nxt;
  logic [7:0] goal_y_r;
  logic [7:0] goal_y_nxt;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    if (wr_en) begin
      if (paddr[2] == vcts_pkg::REG_GOAL_X) begin
        goal_x_nxt = pwdata[7:0];
      end else begin
        goal_y_nxt = pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= vcts_pkg::GOAL_X_RESET;
      goal_y_r <= vcts_pkg::GOAL_Y_RESET;
    end else begin
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
    end
  end

  // Return zero for unaligned reads
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == vcts_pkg::REG_GOAL_X) begin
        prdata = {24'd0, goal_x_r};
      end else begin
        prdata = {24'd0, goal_y_r};
      end
    end
  end

  assign goal_x = goal_x_r;
  assign goal_y = goal_y_r;

endmodule

// ===== src/vcts_seq.sv =====
// Scan sequencer: walks the trail top down through one shared comparator,
// then truncates, pushes or flags overflow, and registers the result.
// Depends on vcts_pkg for the state type and result record.
module vcts_seq #(
  parameter int unsigned TRAIL_DEPTH = 256,
  parameter int unsigned COORD_BITS  = 8,
  localparam int unsigned AW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1,
  localparam int unsigned TW = $clog2(TRAIL_DEPTH + 1),
  localparam int unsigned EW = 2 * COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [7:0]           cell_x,
  input  logic [7:0]           cell_y,
  input  logic [7:0]           goal_x,
  input  logic [7:0]           goal_y,
  output logic                 busy,
  output logic                 res_valid,
  output vcts_pkg::result_t    res,
  output logic [AW-1:0]        mem_raddr,
  input  logic [EW-1:0]        mem_rdata,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [EW-1:0]        mem_wdata
);

  localparam logic [TW-1:0] DEPTH_V = TW'(TRAIL_DEPTH);

  vcts_pkg::state_t  state_r, state_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic [TW-1:0]     top_r, top_nxt;
  logic [TW-1:0]     left_r, left_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     paddr_r, paddr_nxt;
  logic              vld_r, vld_nxt;
  vcts_pkg::result_t res_r, res_nxt;

  logic issue;
  logic hit;
  logic done;

  // Shared comparator: entry read last cycle against the requested cell
  assign hit   = pend_r && (mem_rdata == {x_r, y_r});
  assign issue = (left_r != '0);
  assign done  = hit || !issue;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vcts_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = vcts_pkg::ST_SCAN;
        end
      end
      vcts_pkg::ST_SCAN: begin
        if (done) begin
          state_nxt = vcts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vcts_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    top_nxt   = top_r;
    left_nxt  = left_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    paddr_nxt = paddr_r;
    vld_nxt   = 1'b0;
    res_nxt   = res_r;
    mem_raddr = ptr_r;
    mem_we    = 1'b0;
    mem_waddr = AW'(top_r);
    mem_wdata = {x_r, y_r};
    unique case (state_r)
      vcts_pkg::ST_IDLE: begin
        if (start) begin
          x_nxt    = COORD_BITS'(cell_x);
          y_nxt    = COORD_BITS'(cell_y);
          left_nxt = top_r;
          ptr_nxt  = AW'(top_r - TW'(1));
          pend_nxt = 1'b0;
        end
      end
      vcts_pkg::ST_SCAN: begin
        pend_nxt = issue && !hit;
        if (issue) begin
          ptr_nxt   = ptr_r - AW'(1);
          left_nxt  = left_r - TW'(1);
          paddr_nxt = ptr_r;
        end
        res_nxt.found    = 1'b0;
        res_nxt.overflow = 1'b0;
        if (hit) begin
          // Cut the trail back so the matched entry is the top
          top_nxt       = TW'(paddr_r) + TW'(1);
          res_nxt.found = 1'b1;
        end else if (!issue) begin
          if (top_r < DEPTH_V) begin
            mem_we  = 1'b1;
            top_nxt = top_r + TW'(1);
          end else begin
            res_nxt.overflow = 1'b1;
          end
        end
        if (done) begin
          vld_nxt         = 1'b1;
          res_nxt.length  = vcts_pkg::LEN_W'(top_nxt);
          res_nxt.at_goal = (x_r == COORD_BITS'(goal_x)) && (y_r == COORD_BITS'(goal_y));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcts_pkg::ST_IDLE;
      top_r   <= '0;
      left_r  <= '0;
      pend_r  <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    ptr_r   <= ptr_nxt;
    paddr_r <= paddr_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (state_r != vcts_pkg::ST_IDLE);
  assign res_valid = vld_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= DEPTH_V)
    else $error("trail pointer beyond depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (state_r == vcts_pkg::ST_IDLE))
    else $error("result strobe while scanning");

  a_found_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> !(res_r.found && res_r.overflow))
    else $error("match and overflow reported together");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.overflow) |-> (top_r == DEPTH_V))
    else $error("overflow with room on the trail");

  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vcts_pkg::ST_IDLE && start) |=> (state_r == vcts_pkg::ST_SCAN))
    else $error("accepted request did not start a scan");
`endif

endmodule

// ===== src/visited_cell_trail_stack_core.sv =====
// Top level of the visited-cell trail stack (loop-erased path stack).
// Depends on vcts_pkg, vcts_cfg, vcts_trail_mem and vcts_seq.
//
// Each request carries the cell the robot just reached. The core searches the
// live trail from the top down, one entry per clock through a single
// comparator fed by the trail memory's registered read port. On a match the
// trail is cut back so the matched cell becomes the top; otherwise the cell is
// pushed, or dropped and flagged as overflow when the trail is full. busy goes
// high the cycle after start is taken and stays high while the trail is
// scanned: the whole trail when the cell is not found, down to the matched
// entry on a match. The result strobe out_valid is registered from the last
// scan step, so busy is already low when it rises and a new request can be
// taken. The linear memory scan covers at most TRAIL_DEPTH entries per
// request. out_valid lasts exactly one cycle and cannot be held off, so the
// receiver must capture the result fields on that cycle. The goal registers
// sit at byte addresses 0 (goal_x) and 4 (goal_y), reset to 2, and should be
// written only while no request is in flight. The trail memory is not cleared
// at reset; only entries below the trail pointer are ever read.
module visited_cell_trail_stack_core #(
  parameter int unsigned TRAIL_DEPTH = 256,
  parameter int unsigned COORD_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_cell_x,
  input  logic [7:0]  in_cell_y,
  // result channel
  output logic        out_valid,
  output logic        out_found_on_trail,
  output logic [8:0]  out_trail_length,
  output logic        out_overflow,
  output logic        out_at_goal,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int unsigned EW = 2 * COORD_BITS;

  logic [7:0]        goal_x;
  logic [7:0]        goal_y;
  logic [AW-1:0]     mem_raddr;
  logic [EW-1:0]     mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  vcts_pkg::result_t res;

  // Registers are always ready: no wait states
  assign pready = 1'b1;

  vcts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .goal_x  (goal_x),
    .goal_y  (goal_y)
  );

  // Trail storage: one packed {x, y} entry per slot
  vcts_trail_mem #(
    .DEPTH (TRAIL_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: scan, truncate, push or flag overflow, and register the result
  vcts_seq #(
    .TRAIL_DEPTH (TRAIL_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cell_x    (in_cell_x),
    .cell_y    (in_cell_y),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .busy      (busy),
    .res_valid (out_valid),
    .res       (res),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // Unpack the registered result onto the ports
  assign out_found_on_trail = res.found;
  assign out_trail_length   = res.length;
  assign out_overflow       = res.overflow;
  assign out_at_goal        = res.at_goal;

endmodule
